[rtl/core/hscc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hscc_pkg: shared types and functions for the hypercube canonical check
// Sequencer states, axis order types and the small arithmetic helpers.
// ----------------------------------------------------------------------------
package hscc_pkg;

    localparam int MAX_DIM  = 5;
    localparam int WORD_W   = 1 << MAX_DIM;
    localparam int AXIS_W   = 3;
    localparam int ORBIT_W  = 12;
    localparam int DIV_STEPS = ORBIT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    // perm[l]: source axis of image axis l
    typedef logic [MAX_DIM-1:0][AXIS_W-1:0] perm_t;
    // mixed-radix code, digit j counts 0..j; digit 0 unused
    typedef logic [MAX_DIM-1:0][AXIS_W-1:0] code_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

    function automatic logic [AXIS_W-1:0] eff_dim(input logic [AXIS_W-1:0] d);
        logic [AXIS_W-1:0] r;
        if (d == '0) begin
            r = AXIS_W'(1);
        end else if (d > AXIS_W'(MAX_DIM)) begin
            r = AXIS_W'(MAX_DIM);
        end else begin
            r = d;
        end
        return r;
    endfunction

    function automatic logic [ORBIT_W-1:0] group_order(input logic [AXIS_W-1:0] d);
        logic [ORBIT_W-1:0] r;
        unique case (d)
            3'd1:    r = ORBIT_W'(2);
            3'd2:    r = ORBIT_W'(8);
            3'd3:    r = ORBIT_W'(48);
            3'd4:    r = ORBIT_W'(384);
            default: r = ORBIT_W'(3840);
        endcase
        return r;
    endfunction

    function automatic logic [MAX_DIM-1:0] refl_mask(input logic [AXIS_W-1:0] d);
        logic [MAX_DIM:0] full;
        full = (MAX_DIM+1)'(1) << d;
        return MAX_DIM'(full - (MAX_DIM+1)'(1));
    endfunction

    // Build an axis order by inserting axis j at position j - digit j.
    // Codes below d! leave axes d and up in place.
    function automatic perm_t perm_from_code(input code_t code);
        perm_t arr;
        perm_t nxt;
        logic [AXIS_W-1:0] pos;
        arr = '0;
        for (int j = 1; j < MAX_DIM; j++) begin
            pos = AXIS_W'(j) - code[j];
            nxt = arr;
            for (int i = 0; i < MAX_DIM; i++) begin
                if (i <= j) begin
                    if (AXIS_W'(i) < pos) begin
                        nxt[i] = arr[i];
                    end else if (AXIS_W'(i) == pos) begin
                        nxt[i] = AXIS_W'(j);
                    end else begin
                        nxt[i] = arr[(i > 0) ? i - 1 : 0];
                    end
                end
            end
            arr = nxt;
        end
        return arr;
    endfunction

endpackage

[rtl/core/hypercube_symmetry_canon_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hypercube_symmetry_canon_check: canonical form and orbit size of a vertex set
// Scan: one image per cycle, up to 2^d * d! images, stopping at the first
//   smaller image; canonical words then pass through the divider, and every
//   result through the output state. One request at a time; the next can be
//   taken in the cycle that the result appears.
// The dimension and the image compare set the scan length; a 1-bit-per-cycle divider gives size.
// Synchronous active-low reset clears the sequencer, output valid, and sets
//   dimension to 5.
// ----------------------------------------------------------------------------
module hypercube_symmetry_canon_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_dimension,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] selection
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] canonical, [12:1] orbit_size, [15:13] zero
);

    localparam int MD = hscc_pkg::MAX_DIM;
    localparam int AW = hscc_pkg::AXIS_W;
    localparam int OW = hscc_pkg::ORBIT_W;
    localparam int WW = hscc_pkg::WORD_W;
    localparam int CW = hscc_pkg::DIV_CNT_W;
    localparam int DIV_STEPS_LAST = hscc_pkg::DIV_STEPS - 1;

    hscc_pkg::state_t state_reg, state_next;

    logic [AW-1:0]     cfg_dim_reg;
    logic [WW-1:0]     word_reg, word_next;
    logic [AW-1:0]     dim_reg, dim_next;
    logic [MD-1:0]     refl_reg, refl_next;
    hscc_pkg::code_t   code_reg, code_next;
    hscc_pkg::perm_t   perm_reg, perm_next;
    logic [OW-1:0]     fixed_reg, fixed_next;
    logic [OW-1:0]     rem_reg, rem_next;
    logic [OW-1:0]     quo_reg, quo_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              res_canon_reg, res_canon_next;
    logic [OW-1:0]     res_orbit_reg, res_orbit_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              m_canon_reg, m_canon_next;
    logic [OW-1:0]     m_orbit_reg, m_orbit_next;

    hscc_pkg::cmp_t    cmp;
    logic              accept;
    logic              last_perm;
    logic              last_refl;
    logic              scan_done;
    logic              div_done;
    logic              out_free;
    logic              carry;
    logic [OW-1:0]     divisor;
    logic [OW:0]       trial;
    logic [OW:0]       diff;

    hscc_image u_image (
        .word (word_reg),
        .refl (refl_reg),
        .perm (perm_reg),
        .dim  (dim_reg),
        .cmp  (cmp)
    );

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        last_perm = 1'b1;
        for (int j = 1; j < MD; j++) begin
            if ((AW'(j) < dim_reg) && (code_reg[j] != AW'(j))) begin
                last_perm = 1'b0;
            end
        end
    end

    assign last_refl = (refl_reg == hscc_pkg::refl_mask(dim_reg));
    assign scan_done = last_perm && last_refl;
    assign div_done  = (cnt_reg == CW'(DIV_STEPS_LAST));

    assign divisor = (fixed_reg == '0) ? OW'(1) : fixed_reg;
    assign trial   = {rem_reg, quo_reg[OW-1]};
    assign diff    = trial - {1'b0, divisor};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hscc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = hscc_pkg::ST_SCAN;
                end
            end
            hscc_pkg::ST_SCAN: begin
                if (cmp.lt) begin
                    state_next = hscc_pkg::ST_OUTPUT;
                end else if (scan_done) begin
                    state_next = hscc_pkg::ST_DIVIDE;
                end
            end
            hscc_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    state_next = hscc_pkg::ST_OUTPUT;
                end
            end
            hscc_pkg::ST_OUTPUT: begin
                if (out_free) begin
                    state_next = hscc_pkg::ST_IDLE;
                end
            end
            default: state_next = hscc_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_tready       = (state_reg == hscc_pkg::ST_IDLE);
        word_next      = word_reg;
        dim_next       = dim_reg;
        refl_next      = refl_reg;
        code_next      = code_reg;
        perm_next      = perm_reg;
        fixed_next     = fixed_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        res_canon_next = res_canon_reg;
        res_orbit_next = res_orbit_reg;
        m_canon_next   = m_canon_reg;
        m_orbit_next   = m_orbit_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        carry          = 1'b1;

        unique case (state_reg)
            hscc_pkg::ST_IDLE: begin
                if (accept) begin
                    word_next  = s_tdata;
                    dim_next   = hscc_pkg::eff_dim(cfg_dim_reg);
                    refl_next  = '0;
                    code_next  = '0;
                    perm_next  = hscc_pkg::perm_from_code('0);
                    fixed_next = '0;
                end
            end
            hscc_pkg::ST_SCAN: begin
                if (cmp.lt) begin
                    res_canon_next = 1'b0;
                    res_orbit_next = '0;
                end else begin
                    fixed_next = fixed_reg + OW'(cmp.eq);
                    if (scan_done) begin
                        quo_next = hscc_pkg::group_order(dim_reg);
                        rem_next = '0;
                        cnt_next = '0;
                    end else if (last_perm) begin
                        refl_next = refl_reg + MD'(1);
                        code_next = '0;
                        perm_next = hscc_pkg::perm_from_code('0);
                    end else begin
                        for (int j = 1; j < MD; j++) begin
                            if (carry) begin
                                if (code_reg[j] == AW'(j)) begin
                                    code_next[j] = '0;
                                end else begin
                                    code_next[j] = code_reg[j] + AW'(1);
                                    carry        = 1'b0;
                                end
                            end
                        end
                        perm_next = hscc_pkg::perm_from_code(code_next);
                    end
                end
            end
            hscc_pkg::ST_DIVIDE: begin
                if (!diff[OW]) begin
                    rem_next = diff[OW-1:0];
                    quo_next = {quo_reg[OW-2:0], 1'b1};
                end else begin
                    rem_next = trial[OW-1:0];
                    quo_next = {quo_reg[OW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CW'(1);
                if (div_done) begin
                    res_canon_next = 1'b1;
                    res_orbit_next = quo_next;
                end
            end
            hscc_pkg::ST_OUTPUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_canon_next  = res_canon_reg;
                    m_orbit_next  = res_orbit_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hscc_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cfg_dim_reg  <= AW'(hscc_pkg::MAX_DIM);
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                cfg_dim_reg <= cfg_dimension;
            end
        end
    end

    always_ff @(posedge aclk) begin
        word_reg      <= word_next;
        dim_reg       <= dim_next;
        refl_reg      <= refl_next;
        code_reg      <= code_next;
        perm_reg      <= perm_next;
        fixed_reg     <= fixed_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        res_canon_reg <= res_canon_next;
        res_orbit_reg <= res_orbit_next;
        m_canon_reg   <= m_canon_next;
        m_orbit_reg   <= m_orbit_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_orbit_reg, m_canon_reg};

endmodule

[rtl/core/hscc_image.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hscc_image: one cube symmetry image and its compare against the word
// Permutes the axes of each vertex index, reflects it and compares the result.
// ----------------------------------------------------------------------------
module hscc_image (
    input  logic [hscc_pkg::WORD_W-1:0]  word,
    input  logic [hscc_pkg::MAX_DIM-1:0] refl,
    input  hscc_pkg::perm_t              perm,
    input  logic [hscc_pkg::AXIS_W-1:0]  dim,
    output hscc_pkg::cmp_t               cmp
);

    logic [hscc_pkg::WORD_W-1:0]  img;
    logic [hscc_pkg::MAX_DIM-1:0] kv;
    logic [hscc_pkg::MAX_DIM-1:0] src;

    always_comb begin
        img = '0;
        kv  = '0;
        src = '0;
        for (int k = 0; k < hscc_pkg::WORD_W; k++) begin
            kv  = hscc_pkg::MAX_DIM'(k);
            src = '0;
            for (int l = 0; l < hscc_pkg::MAX_DIM; l++) begin
                if (hscc_pkg::AXIS_W'(l) < dim) begin
                    src[l] = kv[perm[l]];
                end
            end
            src = src ^ refl;
            if ((kv >> dim) == '0) begin
                img[k] = word[src];
            end
        end
    end

    assign cmp.lt = (img < word);
    assign cmp.eq = (img == word);

endmodule

[tb/hypercube_symmetry_canon_check_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hypercube_symmetry_canon_check_tb: self-checking bench for the canon check
// Sends vertex selections under every dimension setting, including the
// out-of-range ones. Each request is predicted from a table of all cube
// symmetries, and results are checked in order. Both stream sides idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module hypercube_symmetry_canon_check_tb;

    localparam int GROUP_MAX = 3840;
    localparam int LONG_HOLD = 400;
    localparam int PHASE_ITEMS = 15;
    localparam int NUM_PHASES = 10;

    localparam logic [31:0] D5_WORDS [12] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
        32'h0000_0003, 32'h0001_0001, 32'h0000_0017, 32'h0000_FFFF,
        32'h6996_9669, 32'h5555_5555, 32'h7FFF_FFFF, 32'h0000_0116
    };
    localparam logic [31:0] D1_WORDS [6] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
        32'h0000_0003, 32'h0000_0004, 32'hFFFF_FFFC
    };
    localparam logic [2:0] PHASE_DIMS [NUM_PHASES] = '{
        3'd1, 3'd0, 3'd2, 3'd3, 3'd4, 3'd7, 3'd6, 3'd5, 3'd3, 3'd2
    };

    typedef struct {
        logic [31:0]                  selection;
        logic                         canonical;
        logic [hscc_pkg::ORBIT_W-1:0] orbit_size;
    } orbit_result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [2:0]  cfg_dimension = 3'd0;
    logic        s_tvalid      = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata       = '0;
    logic        m_tvalid;
    logic        m_tready      = 1'b0;
    logic [15:0] m_tdata;

    logic [31:0]   pending_sel[$];
    orbit_result_t orbit_expected[$];

    // symmetry g: image bit k takes selection bit cube_src[g][k]
    logic [4:0]  cube_src [0:GROUP_MAX-1][0:31];
    int unsigned group_size   = 0;
    int unsigned cube_bits    = 0;
    int unsigned err_count    = 0;
    int unsigned results_seen = 0;
    bit          quiet        = 1'b0;
    int unsigned src_gap      = 0;
    int unsigned sink_gap     = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;

    hypercube_symmetry_canon_check dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_dimension (cfg_dimension),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void build_symmetry_table(input logic [2:0] dim_reg);
        int unsigned d, fact, code, pick, g, src;
        int unsigned c, i, l, k, refl;
        int unsigned axis_order[5];
        int unsigned spare[$];
        if (dim_reg == 3'd0) begin
            d = 1;
        end else if (dim_reg > hscc_pkg::MAX_DIM) begin
            d = hscc_pkg::MAX_DIM;
        end else begin
            d = dim_reg;
        end
        cube_bits = 1 << d;
        fact = 1;
        for (i = 2; i <= d; i++) fact *= i;
        group_size = cube_bits * fact;
        g = 0;
        for (c = 0; c < fact; c++) begin
            spare.delete();
            for (i = 0; i < d; i++) spare.push_back(i);
            code = c;
            for (l = 0; l < d; l++) begin
                pick = code % (d - l);
                code = code / (d - l);
                axis_order[l] = spare[pick];
                spare.delete(pick);
            end
            for (refl = 0; refl < cube_bits; refl++) begin
                for (k = 0; k < cube_bits; k++) begin
                    src = 0;
                    for (l = 0; l < d; l++) src |= ((k >> axis_order[l]) & 1) << l;
                    cube_src[g][k] = 5'(src ^ refl);
                end
                g++;
            end
        end
    endfunction

    function automatic logic [31:0] image_under(input int unsigned g, input logic [31:0] word);
        logic [31:0] img;
        int unsigned k;
        img = '0;
        for (k = 0; k < cube_bits; k++) img[k] = word[cube_src[g][k]];
        return img;
    endfunction

    function automatic orbit_result_t predict_orbit(input logic [31:0] word);
        orbit_result_t r;
        logic [31:0]   img;
        int unsigned   g, fixed;
        bit            smaller;
        fixed = 0;
        smaller = 1'b0;
        for (g = 0; g < group_size && !smaller; g++) begin
            img = image_under(g, word);
            if (img < word) begin
                smaller = 1'b1;
            end else if (img == word) begin
                fixed++;
            end
        end
        if (fixed == 0) fixed = 1;
        r.selection = word;
        r.canonical = !smaller;
        r.orbit_size = smaller ? '0 : hscc_pkg::ORBIT_W'(group_size / fixed);
        return r;
    endfunction

    function automatic logic [31:0] least_image(input logic [31:0] word);
        logic [31:0] best, img;
        int unsigned g;
        best = word;
        for (g = 0; g < group_size; g++) begin
            img = image_under(g, word);
            if (img < best) best = img;
        end
        return best;
    endfunction

    // mostly canonical forms and in-range words; some noise above the cube
    function automatic logic [31:0] random_selection();
        logic [31:0] w, mask;
        int unsigned kind;
        mask = (cube_bits == 32) ? 32'hFFFF_FFFF : (32'd1 << cube_bits) - 32'd1;
        w = $urandom;
        case ($urandom_range(0, 2))
            0:       w &= $urandom & $urandom;
            1:       w |= $urandom;
            default: ;
        endcase
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            w = least_image(w & mask);
        end else if (kind < 8) begin
            w &= mask;
        end else if (kind == 9) begin
            w = 32'd1 << $urandom_range(0, cube_bits - 1);
        end
        return w;
    endfunction

    task automatic flag_error(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        err_count++;
    endtask

    task automatic check_result(input logic [15:0] beat);
        orbit_result_t want;
        results_seen++;
        if (orbit_expected.size() == 0) begin
            flag_error($sformatf("result %h with no request outstanding", beat));
            return;
        end
        want = orbit_expected.pop_front();
        if (beat[0] !== want.canonical)
            flag_error($sformatf("sel %h canonical got %b want %b",
                                 want.selection, beat[0], want.canonical));
        if (beat[12:1] !== want.orbit_size)
            flag_error($sformatf("sel %h orbit_size got %0d want %0d",
                                 want.selection, beat[12:1], want.orbit_size));
    endtask

    task automatic set_dimension(input logic [2:0] value);
        @(posedge aclk);
        cfg_wr_en     <= 1'b1;
        cfg_dimension <= value;
        build_symmetry_table(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_sel.size() != 0 || s_tvalid || orbit_expected.size() != 0);
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready) orbit_expected.push_back(predict_orbit(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    s_tvalid <= 1'b0;
                    src_gap  <= src_gap - 1;
                end else if (pending_sel.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_sel.pop_front();
                    if (!quiet && $urandom_range(0, 4) == 0) src_gap <= $urandom_range(1, 4);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long back-pressure stretch while requests are still queued
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && !quiet && results_seen >= 30 && pending_sel.size() > 4) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (sink_gap != 0) begin
                m_tready <= 1'b0;
                sink_gap <= sink_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0) sink_gap <= $urandom_range(1, 4);
            end
        end
    end

    initial begin
        int p, i;
        build_symmetry_table(3'd5);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset dimension of 5, no write yet
        @(negedge aclk);
        foreach (D5_WORDS[i]) pending_sel.push_back(D5_WORDS[i]);
        wait_idle();

        set_dimension(3'd1);
        @(negedge aclk);
        foreach (D1_WORDS[i]) pending_sel.push_back(D1_WORDS[i]);
        wait_idle();

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) quiet = 1'b1;
            set_dimension(PHASE_DIMS[p]);
            @(negedge aclk);
            for (i = 0; i < PHASE_ITEMS; i++) pending_sel.push_back(random_selection());
            wait_idle();
        end

        repeat (4000) @(posedge aclk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
